FILE: src/potb_pkg.sv
`timescale 1ns / 1ps

package potb_pkg;

   // Bank geometry
   localparam int NUM_TIMERS = 16;
   localparam int TICK_WIDTH = 32;
   localparam int PTR_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int CNT_W      = $clog2(NUM_TIMERS + 1);

   // Action codes
   localparam logic [2:0] ACT_INIT   = 3'd0;
   localparam logic [2:0] ACT_SET    = 3'd1;
   localparam logic [2:0] ACT_RELOAD = 3'd2;
   localparam logic [2:0] ACT_DELETE = 3'd3;
   localparam logic [2:0] ACT_ELAPSE = 3'd4;
   localparam logic [2:0] ACT_QUERY  = 3'd5;

   // Result kinds
   localparam logic [1:0] KIND_ACK     = 2'd0;
   localparam logic [1:0] KIND_EXPIRY  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // Result of the shared saturating subtractor
   typedef struct packed {
      logic [TICK_WIDTH-1:0] value;
      logic                  reached_zero;
   } sub_res_type;

endpackage

FILE: src/potb_satsub.sv
`timescale 1ns / 1ps

// Saturating countdown unit shared by every timer during a sweep
module potb_satsub (
   input  logic [potb_pkg::TICK_WIDTH-1:0] count,
   input  logic [potb_pkg::TICK_WIDTH-1:0] delta,
   output potb_pkg::sub_res_type           res
);
   import potb_pkg::*;

   always_comb begin
      if (count >= delta) begin
         res.value = count - delta;
      end else begin
         res.value = '0;
      end
      res.reached_zero = (res.value == '0);
   end

endmodule

FILE: src/periodic_oneshot_timer_bank.sv
`timescale 1ns / 1ps

// Channel   | ports                                   | direction
// ----------+-----------------------------------------+----------
// request   | req_valid, req_stall, req_action ...    | in
// response  | rsp_valid, rsp_stall, rsp_notice_kind.. | out
//
// A single action registers its response word in ST_OP once the response register is free.
// Elapse sweeps one timer per cycle through one shared subtractor, holding on an expiring
// timer while rsp_stall holds the previous word; a summary word follows the sweep.
// One request at a time; req_stall is high from accept until its last word is registered.
// Synchronous active-high reset frees every timer; counts of free timers read as zero.
module periodic_oneshot_timer_bank (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [3:0]  req_timer_index,
   input  logic [31:0] req_period_ticks,
   input  logic        req_one_shot,
   input  logic [31:0] req_elapsed_ticks,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_notice_kind,
   output logic [3:0]  rsp_index_out,
   output logic        rsp_expired,
   output logic [31:0] rsp_remaining,
   output logic [4:0]  rsp_expiry_count,
   output logic        rsp_last
);
   import potb_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_OP    = 2'd1;
   localparam logic [1:0] ST_SWEEP = 2'd2;
   localparam logic [1:0] ST_SUM   = 2'd3;

   // Timer storage
   logic [TICK_WIDTH-1:0] cnt_mem [NUM_TIMERS];
   logic [TICK_WIDTH-1:0] per_mem [NUM_TIMERS];
   logic                  shot_mem[NUM_TIMERS];
   logic [NUM_TIMERS-1:0] use_ff, use_in;

   // Sequencer and latched request
   logic [1:0]            state_ff, state_in;
   logic [PTR_W-1:0]      ptr_ff, ptr_in;
   logic [CNT_W-1:0]      hits_ff, hits_in;
   logic [2:0]            act_ff;
   logic [3:0]            idx_ff;
   logic [TICK_WIDTH-1:0] period_ff;
   logic                  shot_ff;
   logic [TICK_WIDTH-1:0] delta_ff;

   // Response register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [1:0]            kind_ff;
   logic [3:0]            index_ff;
   logic                  expired_ff;
   logic [31:0]           remain_ff;
   logic [4:0]            ecount_ff;
   logic                  last_ff;

   // Write and load strobes
   logic                  cnt_we, per_we, shot_we, load;
   logic [TICK_WIDTH-1:0] cnt_wd, per_wd;
   logic                  shot_wd;
   logic [1:0]            kind_in;
   logic [3:0]            index_in;
   logic                  expired_in;
   logic [TICK_WIDTH-1:0] remain_in;
   logic                  last_in;

   logic                  accept, out_free, in_bank;
   logic [PTR_W-1:0]      addr;
   logic                  rd_use;
   logic [TICK_WIDTH-1:0] rd_cnt, rd_per;
   logic                  rd_shot;
   sub_res_type           sub;

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign in_bank  = (int'(idx_ff) < NUM_TIMERS);
   assign req_stall = (state_ff != ST_IDLE);

   // One read port: sweep pointer or addressed timer
   assign addr    = (state_ff == ST_SWEEP) ? ptr_ff : PTR_W'(idx_ff);
   assign rd_use  = use_ff[addr];
   assign rd_cnt  = rd_use ? cnt_mem[addr] : '0;
   assign rd_per  = rd_use ? per_mem[addr] : '0;
   assign rd_shot = shot_mem[addr];

   potb_satsub u_sub (
      .count (rd_cnt),
      .delta (delta_ff),
      .res   (sub)
   );

   // Sequencer
   always_comb begin
      logic active, advance;
      active     = rd_use && (rd_cnt != '0) && (delta_ff != '0);
      advance    = 1'b0;
      state_in   = state_ff;
      ptr_in     = ptr_ff;
      hits_in    = hits_ff;
      use_in     = use_ff;
      cnt_we     = 1'b0;
      per_we     = 1'b0;
      shot_we    = 1'b0;
      cnt_wd     = '0;
      per_wd     = '0;
      shot_wd    = 1'b0;
      load       = 1'b0;
      kind_in    = KIND_ACK;
      index_in   = idx_ff;
      expired_in = 1'b0;
      remain_in  = '0;
      last_in    = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ptr_in  = '0;
               hits_in = '0;
               if (req_action == ACT_ELAPSE) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_OP;
               end
            end
         end
         ST_OP: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               if (in_bank) begin
                  unique case (act_ff)
                     ACT_INIT: begin
                        cnt_we       = 1'b1;
                        per_we       = 1'b1;
                        shot_we      = 1'b1;
                        shot_wd      = shot_ff;
                        use_in[addr] = 1'b1;
                     end
                     ACT_SET: begin
                        cnt_we    = rd_use;
                        per_we    = rd_use;
                        cnt_wd    = period_ff;
                        per_wd    = period_ff;
                        remain_in = rd_use ? period_ff : '0;
                     end
                     ACT_RELOAD: begin
                        cnt_we    = rd_use;
                        cnt_wd    = rd_per;
                        remain_in = rd_per;
                     end
                     ACT_DELETE: begin
                        use_in[addr] = 1'b0;
                     end
                     ACT_QUERY: begin
                        remain_in  = rd_cnt;
                        expired_in = (rd_cnt == '0);
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         ST_SWEEP: begin
            advance = !(active && sub.reached_zero) || out_free;
            if (active && advance) begin
               cnt_we = 1'b1;
               cnt_wd = (sub.reached_zero && !rd_shot) ? rd_per : sub.value;
            end
            if (active && sub.reached_zero && out_free) begin
               load       = 1'b1;
               kind_in    = KIND_EXPIRY;
               index_in   = 4'(ptr_ff);
               expired_in = 1'b1;
               remain_in  = cnt_wd;
               last_in    = 1'b0;
               hits_in    = hits_ff + 1'b1;
            end
            if (advance) begin
               if (int'(ptr_ff) == NUM_TIMERS - 1) begin
                  state_in = ST_SUM;
               end else begin
                  ptr_in = ptr_ff + 1'b1;
               end
            end
         end
         ST_SUM: begin
            if (out_free) begin
               load     = 1'b1;
               kind_in  = KIND_SUMMARY;
               index_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = load || (rsp_valid_ff && rsp_stall);
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         use_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         ptr_ff       <= '0;
         hits_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         use_ff       <= use_in;
         rsp_valid_ff <= rsp_valid_in;
         ptr_ff       <= ptr_in;
         hits_ff      <= hits_in;
      end
   end

   // Request capture, ticks trimmed to counter width
   always_ff @(posedge clock) begin
      if (accept) begin
         act_ff    <= req_action;
         idx_ff    <= req_timer_index;
         period_ff <= TICK_WIDTH'(req_period_ticks);
         shot_ff   <= req_one_shot;
         delta_ff  <= TICK_WIDTH'(req_elapsed_ticks);
      end
   end

   // Timer storage writes
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[addr] <= cnt_wd;
      end
      if (per_we) begin
         per_mem[addr] <= per_wd;
      end
      if (shot_we) begin
         shot_mem[addr] <= shot_wd;
      end
   end

   // Response word
   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff    <= kind_in;
         index_ff   <= index_in;
         expired_ff <= expired_in;
         remain_ff  <= 32'(remain_in);
         ecount_ff  <= (kind_in == KIND_SUMMARY) ? 5'(hits_ff) : 5'd0;
         last_ff    <= last_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_notice_kind  = kind_ff;
   assign rsp_index_out    = index_ff;
   assign rsp_expired      = expired_ff;
   assign rsp_remaining    = remain_ff;
   assign rsp_expiry_count = ecount_ff;
   assign rsp_last         = last_ff;

endmodule

FILE: src/potb_checker.sv
`timescale 1ns / 1ps

module potb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_notice_kind,
   input logic        rsp_expired,
   input logic [31:0] rsp_remaining,
   input logic [4:0]  rsp_expiry_count,
   input logic        rsp_last
);
   import potb_pkg::*;

   // Reset empties the response register and opens the request side
   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid && !req_stall)
      else $error("response word valid or request stalled after reset");

   // Stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_remaining)
         && $stable(rsp_notice_kind) && $stable(rsp_last))
      else $error("stalled response word changed");

   // Summary closes a sweep
   a_sum_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notice_kind == KIND_SUMMARY |-> rsp_last && !rsp_expired)
      else $error("summary word not marked last");

   // Expiry notices are never last
   a_exp_notice: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notice_kind == KIND_EXPIRY |-> rsp_expired && !rsp_last
         && rsp_expiry_count == 5'd0)
      else $error("malformed expiry notice");

   // Acknowledge is the only word of its request
   a_ack_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_notice_kind == KIND_ACK |-> rsp_last && rsp_expiry_count == 5'd0)
      else $error("malformed acknowledge word");

endmodule

bind periodic_oneshot_timer_bank potb_checker u_potb_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_notice_kind  (rsp_notice_kind),
   .rsp_expired      (rsp_expired),
   .rsp_remaining    (rsp_remaining),
   .rsp_expiry_count (rsp_expiry_count),
   .rsp_last         (rsp_last)
);

FILE: dv/periodic_oneshot_timer_bank_test.sv
`timescale 1ns / 1ps

module periodic_oneshot_timer_bank_test;
   import potb_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RANDOM_ITEMS   = 156;
   localparam int QUIET_ITEMS    = 30;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 2 * NUM_TIMERS + 8;

   // Action codes the block does not define; it must acknowledge and ignore them
   localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
   localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [3:0]  idx;
      logic [31:0] period;
      logic        one_shot;
      logic [31:0] elapsed;
   } timer_request_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [3:0]  idx;
      logic        expired;
      logic [31:0] remaining;
      logic [4:0]  count;
      logic        last;
   } timer_notice_type;

   typedef struct {
      timer_request_type req;
      bit                typed;
      timer_notice_type  word;
   } stim_row_type;

   // DUT connections
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [3:0]  req_timer_index = '0;
   logic [31:0] req_period_ticks = '0;
   logic        req_one_shot = 1'b0;
   logic [31:0] req_elapsed_ticks = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_notice_kind;
   logic [3:0]  rsp_index_out;
   logic        rsp_expired;
   logic [31:0] rsp_remaining;
   logic [4:0]  rsp_expiry_count;
   logic        rsp_last;

   // Shadow copy of the timer bank
   logic [31:0]      timer_count  [NUM_TIMERS];
   logic [31:0]      timer_period [NUM_TIMERS];
   logic             timer_one_shot [NUM_TIMERS];
   logic             timer_in_use [NUM_TIMERS];
   timer_notice_type pending_notices [$];

   bit quiet_run = 1'b0;
   int mismatch_count = 0;
   int requests_sent = 0;
   int words_checked = 0;
   int expiry_words = 0;
   int stall_left = 0;
   int stuck_cycles = 0;
   stim_row_type directed_rows [$];

   periodic_oneshot_timer_bank i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_timer_index   (req_timer_index),
      .req_period_ticks  (req_period_ticks),
      .req_one_shot      (req_one_shot),
      .req_elapsed_ticks (req_elapsed_ticks),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_notice_kind   (rsp_notice_kind),
      .rsp_index_out     (rsp_index_out),
      .rsp_expired       (rsp_expired),
      .rsp_remaining     (rsp_remaining),
      .rsp_expiry_count  (rsp_expiry_count),
      .rsp_last          (rsp_last)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Apply one request to the shadow bank and queue the words it should produce
   function automatic void advance_timer_bank(timer_request_type r);
      int unsigned fired;
      timer_notice_type n;
      fired = 0;
      if (r.action == ACT_ELAPSE) begin
         for (int t = 0; t < NUM_TIMERS; t++) begin
            if (!timer_in_use[t] || timer_count[t] == 0 || r.elapsed == 0) continue;
            timer_count[t] = (timer_count[t] >= r.elapsed) ? timer_count[t] - r.elapsed : '0;
            if (timer_count[t] == 0) begin
               if (!timer_one_shot[t]) timer_count[t] = timer_period[t];
               n = '{KIND_EXPIRY, 4'(t), 1'b1, timer_count[t], 5'd0, 1'b0};
               pending_notices.push_back(n);
               fired++;
            end
         end
         n = '{KIND_SUMMARY, 4'd0, 1'b0, 32'd0, 5'(fired), 1'b1};
         pending_notices.push_back(n);
         return;
      end
      // Unknown actions and out-of-bank indexes are acknowledged and ignored
      if (r.action > ACT_QUERY || int'(r.idx) >= NUM_TIMERS) begin
         n = '{KIND_ACK, r.idx, 1'b0, 32'd0, 5'd0, 1'b1};
         pending_notices.push_back(n);
         return;
      end
      case (r.action)
         ACT_INIT: begin
            timer_count[r.idx]    = '0;
            timer_period[r.idx]   = '0;
            timer_one_shot[r.idx] = r.one_shot;
            timer_in_use[r.idx]   = 1'b1;
         end
         ACT_SET: begin
            if (timer_in_use[r.idx]) begin
               timer_count[r.idx]  = r.period;
               timer_period[r.idx] = r.period;
            end
         end
         ACT_RELOAD: begin
            if (timer_in_use[r.idx]) timer_count[r.idx] = timer_period[r.idx];
         end
         ACT_DELETE: begin
            timer_count[r.idx]    = '0;
            timer_period[r.idx]   = '0;
            timer_one_shot[r.idx] = 1'b0;
            timer_in_use[r.idx]   = 1'b0;
         end
         default: ;
      endcase
      n = '{KIND_ACK, r.idx, (r.action == ACT_QUERY && timer_count[r.idx] == 0),
            timer_count[r.idx], 5'd0, 1'b1};
      pending_notices.push_back(n);
   endfunction

   function automatic stim_row_type stim_row(logic [2:0] act, logic [3:0] idx,
                                             logic [31:0] period, logic shot,
                                             logic [31:0] elapsed, bit typed,
                                             logic [1:0] kind, logic expired,
                                             logic [31:0] remaining);
      stim_row_type row;
      row.req   = '{act, idx, period, shot, elapsed};
      row.typed = typed;
      row.word  = '{kind, (kind == KIND_SUMMARY) ? 4'd0 : idx, expired, remaining, 5'd0, 1'b1};
      return row;
   endfunction

   function automatic void check_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         mismatch_count++;
      end
   endfunction

   // Drive one request word from a falling edge and wait for its handshake
   task automatic send_request(timer_request_type r, bit typed, timer_notice_type word);
      int gap;
      if (!quiet_run && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 9);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_action        = r.action;
      req_timer_index   = r.idx;
      req_period_ticks  = r.period;
      req_one_shot      = r.one_shot;
      req_elapsed_ticks = r.elapsed;
      do @(posedge clock); while (req_stall);
      advance_timer_bank(r);
      // Hand-typed expectation replaces the predicted single word
      if (typed) begin
         void'(pending_notices.pop_back());
         pending_notices.push_back(word);
      end
      requests_sent++;
      @(negedge clock);
   endtask

   // Response-side stall bursts
   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left--;
         rsp_stall = 1'b1;
      end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall = 1'b1;
      end else begin
         rsp_stall = 1'b0;
      end
   end

   // Response checker
   always @(posedge clock) begin
      timer_notice_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_notices.size() == 0) begin
            $display("%0t: unexpected word, kind %0d index %0d remaining 0x%0h",
                     $time, rsp_notice_kind, rsp_index_out, rsp_remaining);
            mismatch_count++;
         end else begin
            want = pending_notices.pop_front();
            check_field("notice_kind", want.kind, rsp_notice_kind);
            check_field("index_out", want.idx, rsp_index_out);
            check_field("expired", want.expired, rsp_expired);
            check_field("remaining", want.remaining, rsp_remaining);
            check_field("expiry_count", want.count, rsp_expiry_count);
            check_field("last", want.last, rsp_last);
            words_checked++;
            if (want.kind == KIND_EXPIRY) expiry_words++;
         end
      end
   end

   // Watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         stuck_cycles = 0;
      end else begin
         stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d words outstanding",
                     $time, stuck_cycles, pending_notices.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      timer_request_type req;
      int random_sent;
      int pick;
      random_sent = 0;
      for (int t = 0; t < NUM_TIMERS; t++) begin
         timer_count[t]    = '0;
         timer_period[t]   = '0;
         timer_one_shot[t] = 1'b0;
         timer_in_use[t]   = 1'b0;
      end

      // Directed table
      directed_rows.push_back(stim_row(ACT_QUERY,  0, 0, 0, 0,   1, KIND_ACK, 1, 0));
      // elapse over an empty bank
      directed_rows.push_back(stim_row(ACT_ELAPSE, 0, 0, 0, 100, 1, KIND_SUMMARY, 0, 0));
      // set and reload of a free timer do nothing
      directed_rows.push_back(stim_row(ACT_SET,    3, 50, 0, 0,  1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_RELOAD, 3, 0, 0, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_INIT,   0, 0, 0, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_SET,    0, '1, 0, 0,  1, KIND_ACK, 0, '1));
      directed_rows.push_back(stim_row(ACT_INIT,  15, 0, 1, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_SET,   15, 1, 0, 0,   1, KIND_ACK, 0, 1));
      directed_rows.push_back(stim_row(ACT_INIT,   7, 0, 0, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_SET,    7, 10, 0, 0,  1, KIND_ACK, 0, 10));
      // zero elapsed ticks expire nothing
      directed_rows.push_back(stim_row(ACT_ELAPSE, 0, 0, 0, 0,   1, KIND_SUMMARY, 0, 0));
      directed_rows.push_back(stim_row(ACT_ELAPSE, 0, 0, 0, 1,   0, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_QUERY, 15, 0, 0, 0,   1, KIND_ACK, 1, 0));
      // saturating subtract on every running timer
      directed_rows.push_back(stim_row(ACT_ELAPSE, 0, 0, 0, '1,  0, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_RELOAD,15, 0, 0, 0,   0, KIND_ACK, 0, 0));
      // zero period stops the timer
      directed_rows.push_back(stim_row(ACT_SET,    7, 0, 0, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_ELAPSE, 0, 0, 0, 3,   0, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_DELETE, 0, 0, 0, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_QUERY,  0, 0, 0, 0,   1, KIND_ACK, 1, 0));
      directed_rows.push_back(stim_row(ACT_UNUSED_6, 7, 32'hDEAD_BEEF, 1, 32'h1234_5678,
                                       1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_UNUSED_7, 15, '1, 1, '1, 1, KIND_ACK, 0, 0));
      // re-init of a timer already in use
      directed_rows.push_back(stim_row(ACT_INIT,  15, 0, 0, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_DELETE, 5, 0, 0, 0,   1, KIND_ACK, 0, 0));
      directed_rows.push_back(stim_row(ACT_QUERY,  7, 0, 0, 0,   1, KIND_ACK, 1, 0));

      // Reset
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].word);

      // Random part; a full bank sweep with every timer expiring now and then
      while (random_sent < RANDOM_ITEMS) begin
         quiet_run = (random_sent >= RANDOM_ITEMS - QUIET_ITEMS);
         if (random_sent % 90 == 0) begin
            for (int t = 0; t < NUM_TIMERS; t++) begin
               req = '{ACT_INIT, 4'(t), $urandom, 1'($urandom), $urandom};
               send_request(req, 1'b0, '0);
               req = '{ACT_SET, 4'(t), 32'($urandom_range(1, 8)), 1'($urandom), $urandom};
               send_request(req, 1'b0, '0);
            end
            req = '{ACT_ELAPSE, 4'($urandom), $urandom, 1'($urandom),
                    32'($urandom_range(8, 20))};
            send_request(req, 1'b0, '0);
            random_sent += 2 * NUM_TIMERS + 1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 10)      req.action = ACT_INIT;
            else if (pick < 35) req.action = ACT_SET;
            else if (pick < 45) req.action = ACT_RELOAD;
            else if (pick < 50) req.action = ACT_DELETE;
            else if (pick < 72) req.action = ACT_ELAPSE;
            else if (pick < 95) req.action = ACT_QUERY;
            else req.action = $urandom_range(0, 1) ? ACT_UNUSED_6 : ACT_UNUSED_7;
            req.idx      = 4'($urandom);
            req.one_shot = 1'($urandom);
            case ($urandom_range(0, 9))
               0:       req.period = '0;
               1:       req.period = '1;
               2:       req.period = $urandom;
               default: req.period = 32'($urandom_range(1, 40));
            endcase
            case ($urandom_range(0, 9))
               0:       req.elapsed = '0;
               1:       req.elapsed = '1;
               2:       req.elapsed = $urandom;
               default: req.elapsed = 32'($urandom_range(1, 15));
            endcase
            send_request(req, 1'b0, '0);
            random_sent++;
         end
      end
      req_valid = 1'b0;

      // Drain, then give the block time to show any stray word
      while (pending_notices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d requests (%0d from the directed table), checked %0d response words",
               requests_sent, directed_rows.size(), words_checked);
      $display("including %0d expiry notices; %0d mismatches", expiry_words, mismatch_count);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
